FILE: sv/top_k_seed_keeper_top_defines.svh
// ----------------------------------------------------------------------------
// Top-K seed keeper assertion macros
// Shared concurrent assertion forms, clocked on clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TOP_K_SEED_KEEPER_TOP_DEFINES_SVH
`define TOP_K_SEED_KEEPER_TOP_DEFINES_SVH

// same-cycle implication
`define TKSK_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("top_k_seed_keeper check failed");

// next-cycle implication
`define TKSK_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("top_k_seed_keeper check failed");

`endif

FILE: sv/tksk_pkg.sv
// ----------------------------------------------------------------------------
// Top-K seed keeper package
// Entry, cell link and control types plus request and register codes.
// ----------------------------------------------------------------------------
`default_nettype none

package tksk_pkg;

   localparam int FIELD_W  = 16;
   localparam int LIMIT_W  = 7;
   localparam int CSR_IDX_W = 1;

   localparam logic REQ_OFFER = 1'b0;
   localparam logic REQ_DRAIN = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_LENGTH = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEEP_LIMIT = 1'b1;

   typedef struct packed {
      logic [FIELD_W-1:0] len;
      logic [FIELD_W-1:0] first_row;
      logic [FIELD_W-1:0] second_row;
   } entry_type;

   typedef struct packed {
      logic      lt;
      entry_type entry;
   } link_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_REPLACE,
      CELL_SHIFT
   } cell_mode_type;

   typedef struct packed {
      cell_mode_type mode;
      logic          occupied;
   } cell_ctrl_type;

   typedef enum logic {
      ST_IDLE,
      ST_DRAIN
   } state_type;

endpackage

`default_nettype wire

FILE: sv/tksk_cell.sv
// ----------------------------------------------------------------------------
// Top-K seed keeper cell
// One slot of the sorted chain: ranks its entry against the offer and
// holds, loads the offer, or takes a neighbour's entry.
// ----------------------------------------------------------------------------
`default_nettype none

module tksk_cell import tksk_pkg::*; (
   input  wire logic          clock,
   input  wire cell_ctrl_type ctrl,
   input  wire entry_type     offer,
   input  wire link_type      left_link,
   input  wire link_type      right_link,
   output      link_type      link_out
);

   entry_type entry_ff;
   entry_type entry_in;
   logic      lt;

   function automatic logic better(input entry_type a, input entry_type b);
      better = (a.len > b.len) ||
               ((a.len == b.len) && (a.first_row < b.first_row)) ||
               ((a.len == b.len) && (a.first_row == b.first_row) &&
                (a.second_row < b.second_row));
   endfunction

   assign lt = ctrl.occupied && better(offer, entry_ff);

   always_comb begin
      entry_in = entry_ff;
      case (ctrl.mode)
         CELL_INSERT: begin
            if (lt) begin
               entry_in = entry_ff;
            end else if (left_link.lt) begin
               entry_in = offer;
            end else begin
               entry_in = left_link.entry;
            end
         end
         CELL_REPLACE: begin
            if (right_link.lt) begin
               entry_in = right_link.entry;
            end else if (lt) begin
               entry_in = offer;
            end else begin
               entry_in = entry_ff;
            end
         end
         CELL_SHIFT: begin
            entry_in = right_link.entry;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign link_out = '{lt: lt, entry: entry_ff};

endmodule

`default_nettype wire

FILE: sv/top_k_seed_keeper_top.sv
// ----------------------------------------------------------------------------
// Top-K seed keeper
// Keeps the best scored row pairs of a stream in a sorted chain of cells.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries requests: an offer (req_type 0) with a score and two row
//   indices, or a drain (req_type 1). rsp_* returns drain results, worst
//   entry first, rsp_last on the final one; an empty store gives a single
//   result with rsp_entry_valid low. csr_* writes min_length (index 0) and
//   keep_limit (index 1) while the block is idle.
//   Offers are accepted back to back while the block is idle; every cell
//   ranks its entry against the offer in parallel and the chain settles in
//   that same cycle. A drain of n entries shifts the chain once per result:
//   req_stall stays high until the final result is loaded, also while
//   rsp_stall holds a result back. The drain request moves the block into
//   ST_DRAIN, which loads the result register one per cycle unless stalled.
//   rsp_stall holds the result register and pauses the shift; once the
//   final result is loaded, offers flow again while it waits. Reset empties
//   the store, sets min_length to 0 and keep_limit to 64.
// ----------------------------------------------------------------------------
`default_nettype none

`include "top_k_seed_keeper_top_defines.svh"

module top_k_seed_keeper_top import tksk_pkg::*; #(
   parameter int MAX_KEEP = 64
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_stall,
   input  wire logic                 req_type,
   input  wire logic [FIELD_W-1:0]   req_score_len,
   input  wire logic [FIELD_W-1:0]   req_first_row,
   input  wire logic [FIELD_W-1:0]   req_second_row,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   output      logic [FIELD_W-1:0]   rsp_out_len,
   output      logic [FIELD_W-1:0]   rsp_out_first_row,
   output      logic [FIELD_W-1:0]   rsp_out_second_row,
   output      logic                 rsp_entry_valid,
   output      logic                 rsp_last,
   input  wire logic                 csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [FIELD_W-1:0]   csr_wdata
);

   localparam int CNT_W = $clog2(MAX_KEEP + 1);

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [FIELD_W-1:0]   min_len_ff;
   logic [LIMIT_W-1:0]   limit_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   entry_type            rsp_entry_ff, rsp_entry_in;
   logic                 rsp_ev_ff, rsp_ev_in;
   logic                 rsp_last_ff, rsp_last_in;

   entry_type            offer;
   link_type             links [MAX_KEEP];
   cell_mode_type        mode;
   logic [LIMIT_W-1:0]   eff_limit;
   logic                 offer_acc, drain_acc, pass, full, can_load;
   logic                 emit_entry, emit_empty;

   assign offer     = '{len: req_score_len, first_row: req_first_row,
                        second_row: req_second_row};
   assign req_stall = (state_ff != ST_IDLE);
   assign offer_acc = req_valid && !req_stall && (req_type == REQ_OFFER);
   assign drain_acc = req_valid && !req_stall && (req_type == REQ_DRAIN);
   assign eff_limit = (limit_ff > LIMIT_W'(MAX_KEEP)) ? LIMIT_W'(MAX_KEEP) : limit_ff;
   assign pass      = (eff_limit != '0) && (req_score_len >= min_len_ff);
   assign full      = (LIMIT_W'(count_ff) >= eff_limit);
   assign can_load  = !rsp_valid_ff || !rsp_stall;
   assign emit_entry = (state_ff == ST_DRAIN) && can_load && (count_ff != '0);
   assign emit_empty = (state_ff == ST_DRAIN) && can_load && (count_ff == '0);

   genvar gi;
   generate
      for (gi = 0; gi < MAX_KEEP; gi++) begin : g_cell
         cell_ctrl_type ctrl;
         link_type      left_link;
         link_type      right_link;

         assign ctrl = '{mode: mode, occupied: (count_ff > CNT_W'(gi))};

         if (gi == 0) begin : g_head
            assign left_link = '{lt: 1'b1, entry: '0};
         end else begin : g_body
            assign left_link = links[gi-1];
         end

         if (gi == MAX_KEEP - 1) begin : g_tail
            assign right_link = '{lt: 1'b0, entry: '0};
         end else begin : g_inner
            assign right_link = links[gi+1];
         end

         tksk_cell u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .offer      (offer),
            .left_link  (left_link),
            .right_link (right_link),
            .link_out   (links[gi])
         );
      end
   endgenerate

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      mode         = CELL_HOLD;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_entry_in = rsp_entry_ff;
      rsp_ev_in    = rsp_ev_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (offer_acc && pass) begin
               if (!full) begin
                  mode     = CELL_INSERT;
                  count_in = count_ff + CNT_W'(1);
               end else if (links[0].lt) begin
                  mode = CELL_REPLACE;
               end
            end else if (drain_acc) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (emit_entry) begin
               mode         = CELL_SHIFT;
               count_in     = count_ff - CNT_W'(1);
               rsp_valid_in = 1'b1;
               rsp_entry_in = links[0].entry;
               rsp_ev_in    = 1'b1;
               rsp_last_in  = (count_ff == CNT_W'(1));
               if (count_ff == CNT_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end else if (emit_empty) begin
               rsp_valid_in = 1'b1;
               rsp_entry_in = '0;
               rsp_ev_in    = 1'b0;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_entry_ff <= rsp_entry_in;
      rsp_ev_ff    <= rsp_ev_in;
      rsp_last_ff  <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_len_ff <= '0;
         limit_ff   <= LIMIT_W'(64);
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_MIN_LENGTH: min_len_ff <= csr_wdata;
            CSR_KEEP_LIMIT: limit_ff   <= csr_wdata[LIMIT_W-1:0];
            default: begin
               min_len_ff <= min_len_ff;
            end
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_len        = rsp_entry_ff.len;
   assign rsp_out_first_row  = rsp_entry_ff.first_row;
   assign rsp_out_second_row = rsp_entry_ff.second_row;
   assign rsp_entry_valid    = rsp_ev_ff;
   assign rsp_last           = rsp_last_ff;

   `TKSK_ASSERT_IMP(a_count_bound, 1'b1, count_ff <= CNT_W'(MAX_KEEP))
   `TKSK_ASSERT_NXT(a_insert_grows, mode == CELL_INSERT, count_ff == $past(count_ff) + CNT_W'(1))
   `TKSK_ASSERT_NXT(a_final_result_idles, (emit_entry || emit_empty) && rsp_last_in,
      state_ff == ST_IDLE && count_ff == '0)
   `TKSK_ASSERT_IMP(a_empty_is_last, rsp_valid_ff && !rsp_ev_ff, rsp_last_ff)

endmodule

`default_nettype wire

FILE: tb/sv/tb_top_k_seed_keeper_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Top-K seed keeper testbench
// Offers scored row pairs and drain requests to the keeper under bursty
// request traffic and a randomly stalling receiver. A sorted list of the
// kept pairs predicts drain results not set by the directed table. Each
// result is compared field by field, in order. A directed table comes
// first, then random phases over several min_length and keep_limit settings.
// ----------------------------------------------------------------------------

module tb_top_k_seed_keeper_top;
   import tksk_pkg::*;

   localparam int KEEP_CAPACITY = 64;

   typedef struct packed {
      logic [FIELD_W-1:0] len;
      logic [FIELD_W-1:0] first_row;
      logic [FIELD_W-1:0] second_row;
      logic               entry_valid;
      logic               last;
   } keeper_result_type;

   typedef enum logic [1:0] {
      STEP_REQ,
      STEP_SET_MIN,
      STEP_SET_LIMIT
   } plan_kind_type;

   // register steps carry the value in len
   typedef struct {
      plan_kind_type      kind;
      logic               rtype;
      logic [FIELD_W-1:0] len;
      logic [FIELD_W-1:0] first_row;
      logic [FIELD_W-1:0] second_row;
      bit                 typed;
      keeper_result_type  want;
   } plan_row_type;

   typedef struct {
      logic [FIELD_W-1:0] min_len;
      bit                 min_random;
      logic [FIELD_W-1:0] limit_wdata;
      int                 items;
      int                 drain_pct;
      bit                 end_drain;
   } phase_type;

   localparam keeper_result_type EMPTY_DRAIN = '{16'd0, 16'd0, 16'd0, 1'b0, 1'b1};
   localparam keeper_result_type TOP_SINGLE  = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1};

   localparam int PLAN_ROWS = 28;

   plan_row_type directed_plan [PLAN_ROWS] = '{
      '{STEP_REQ, REQ_DRAIN, 16'd0, 16'd0, 16'd0, 1'b1, EMPTY_DRAIN},
      '{STEP_REQ, REQ_OFFER, 16'd0, 16'd0, 16'd0, 1'b0, '0},
      '{STEP_REQ, REQ_OFFER, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, '0},
      '{STEP_REQ, REQ_OFFER, 16'hFFFF, 16'd0, 16'd0, 1'b0, '0},
      '{STEP_REQ, REQ_OFFER, 16'd1000, 16'd5, 16'd7, 1'b0, '0},
      '{STEP_REQ, REQ_OFFER, 16'd1000, 16'd5, 16'd6, 1'b0, '0},
      '{STEP_REQ, REQ_OFFER, 16'd1000, 16'd4, 16'd9, 1'b0, '0},
      '{STEP_REQ, REQ_OFFER, 16'd1000, 16'd5, 16'd7, 1'b0, '0},
      '{STEP_REQ, REQ_DRAIN, 16'd0, 16'd0, 16'd0, 1'b0, '0},
      '{STEP_REQ, REQ_OFFER, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, '0},
      '{STEP_REQ, REQ_DRAIN, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, TOP_SINGLE},
      '{STEP_SET_MIN, REQ_OFFER, 16'hFFFF, 16'd0, 16'd0, 1'b0, '0},
      '{STEP_REQ, REQ_OFFER, 16'hFFFE, 16'd1, 16'd1, 1'b0, '0},
      '{STEP_REQ, REQ_OFFER, 16'hFFFF, 16'd1, 16'd2, 1'b0, '0},
      '{STEP_REQ, REQ_DRAIN, 16'd0, 16'd0, 16'd0, 1'b1,
        '{16'hFFFF, 16'd1, 16'd2, 1'b1, 1'b1}},
      '{STEP_SET_MIN, REQ_OFFER, 16'd0, 16'd0, 16'd0, 1'b0, '0},
      '{STEP_SET_LIMIT, REQ_OFFER, 16'd0, 16'd0, 16'd0, 1'b0, '0},
      '{STEP_REQ, REQ_OFFER, 16'd500, 16'd3, 16'd3, 1'b0, '0},
      '{STEP_REQ, REQ_DRAIN, 16'd0, 16'd0, 16'd0, 1'b1, EMPTY_DRAIN},
      '{STEP_SET_LIMIT, REQ_OFFER, 16'd2, 16'd0, 16'd0, 1'b0, '0},
      '{STEP_REQ, REQ_OFFER, 16'd10, 16'd1, 16'd1, 1'b0, '0},
      '{STEP_REQ, REQ_OFFER, 16'd20, 16'd1, 16'd1, 1'b0, '0},
      '{STEP_REQ, REQ_OFFER, 16'd10, 16'd0, 16'd0, 1'b0, '0},
      '{STEP_REQ, REQ_OFFER, 16'd10, 16'd0, 16'd0, 1'b0, '0},
      '{STEP_REQ, REQ_OFFER, 16'd5, 16'd0, 16'd0, 1'b0, '0},
      '{STEP_SET_LIMIT, REQ_OFFER, 16'd1, 16'd0, 16'd0, 1'b0, '0},
      '{STEP_REQ, REQ_OFFER, 16'd30, 16'd0, 16'd0, 1'b0, '0},
      '{STEP_REQ, REQ_DRAIN, 16'd0, 16'd0, 16'd0, 1'b0, '0}
   };

   localparam int PHASES = 8;

   phase_type random_phases [PHASES] = '{
      '{16'd0, 1'b0, 16'd64, 25, 5, 1'b0},
      '{16'd0, 1'b1, 16'd3, 30, 8, 1'b1},
      '{16'd0, 1'b0, 16'd100, 45, 0, 1'b1},
      '{16'hFFFF, 1'b0, 16'd5, 20, 10, 1'b1},
      '{16'd0, 1'b0, 16'd0, 15, 15, 1'b1},
      '{16'd0, 1'b1, 16'd1, 25, 10, 1'b1},
      '{16'd0, 1'b0, 16'hA587, 20, 10, 1'b1},
      '{16'd0, 1'b0, 16'hFFC1, 20, 10, 1'b1}
   };

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic                 req_type;
   logic [FIELD_W-1:0]   req_score_len;
   logic [FIELD_W-1:0]   req_first_row;
   logic [FIELD_W-1:0]   req_second_row;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [FIELD_W-1:0]   rsp_out_len;
   logic [FIELD_W-1:0]   rsp_out_first_row;
   logic [FIELD_W-1:0]   rsp_out_second_row;
   logic                 rsp_entry_valid;
   logic                 rsp_last;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [FIELD_W-1:0]   csr_wdata;

   // kept pairs, worst first
   entry_type          kept_pairs[$];
   keeper_result_type  drain_results_due[$];
   logic [FIELD_W-1:0] min_len_reg;
   logic [LIMIT_W-1:0] keep_limit_reg;

   int fail_count = 0;
   int burst_left = 0;
   int stall_pct  = 0;
   int stall_hold = 0;

   top_k_seed_keeper_top #(
      .MAX_KEEP (KEEP_CAPACITY)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_score_len      (req_score_len),
      .req_first_row      (req_first_row),
      .req_second_row     (req_second_row),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_len        (rsp_out_len),
      .rsp_out_first_row  (rsp_out_first_row),
      .rsp_out_second_row (rsp_out_second_row),
      .rsp_entry_valid    (rsp_entry_valid),
      .rsp_last           (rsp_last),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic logic [47:0] rank_key(entry_type e);
      return {e.len, ~e.first_row, ~e.second_row};
   endfunction

   function automatic void predict_offer(entry_type e);
      int limit;
      int pos;
      limit = (keep_limit_reg > KEEP_CAPACITY) ? KEEP_CAPACITY : int'(keep_limit_reg);
      if (limit == 0 || e.len < min_len_reg) begin
         return;
      end
      if (kept_pairs.size() >= limit) begin
         if (rank_key(e) <= rank_key(kept_pairs[0])) begin
            return;
         end
         void'(kept_pairs.pop_front());
      end
      pos = 0;
      while (pos < kept_pairs.size() && rank_key(kept_pairs[pos]) <= rank_key(e)) begin
         pos++;
      end
      kept_pairs.insert(pos, e);
   endfunction

   function automatic void predict_drain(ref keeper_result_type results[$]);
      keeper_result_type r;
      if (kept_pairs.size() == 0) begin
         results.push_back(EMPTY_DRAIN);
         return;
      end
      foreach (kept_pairs[i]) begin
         r.len         = kept_pairs[i].len;
         r.first_row   = kept_pairs[i].first_row;
         r.second_row  = kept_pairs[i].second_row;
         r.entry_valid = 1'b1;
         r.last        = (i == kept_pairs.size() - 1);
         results.push_back(r);
      end
      kept_pairs.delete();
   endfunction

   function automatic void check_field(string name, logic [FIELD_W-1:0] want,
                                       logic [FIELD_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endfunction

   task automatic send_request(input logic rtype, input logic [FIELD_W-1:0] len,
                               input logic [FIELD_W-1:0] first_row,
                               input logic [FIELD_W-1:0] second_row,
                               input bit typed, input keeper_result_type want);
      keeper_result_type produced[$];
      int gap;
      @(negedge clock);
      req_valid      <= 1'b1;
      req_type       <= rtype;
      req_score_len  <= len;
      req_first_row  <= first_row;
      req_second_row <= second_row;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      if (rtype == REQ_DRAIN) begin
         predict_drain(produced);
         if (typed) begin
            drain_results_due.push_back(want);
         end else begin
            foreach (produced[i]) begin
               drain_results_due.push_back(produced[i]);
            end
         end
      end else begin
         predict_offer('{len, first_row, second_row});
      end
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap        = $urandom_range(1, 7);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [FIELD_W-1:0] value);
      @(negedge clock);
      req_valid <= 1'b0;
      while (drain_results_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == CSR_MIN_LENGTH) begin
         min_len_reg = value;
      end else begin
         keep_limit_reg = value[LIMIT_W-1:0];
      end
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic send_random_offer();
      logic [FIELD_W-1:0] len;
      logic [FIELD_W-1:0] first_row;
      logic [FIELD_W-1:0] second_row;
      int pick;
      int near;
      pick = $urandom_range(0, 9);
      near = int'(min_len_reg) + int'($urandom_range(0, 3));
      if (pick < 4) begin
         len = FIELD_W'($urandom());
      end else if (pick < 8) begin
         len = (near > 65535) ? 16'hFFFF : near[FIELD_W-1:0];
      end else begin
         len = (min_len_reg == 0) ? 16'd0 : min_len_reg - 16'd1;
      end
      if ($urandom_range(0, 1) == 0) begin
         first_row  = FIELD_W'($urandom());
         second_row = FIELD_W'($urandom());
      end else begin
         first_row  = FIELD_W'($urandom_range(0, 3));
         second_row = FIELD_W'($urandom_range(0, 3));
      end
      send_request(REQ_OFFER, len, first_row, second_row, 1'b0, '0);
   endtask

   // receiver stall pattern: hold a stall rate for a stretch, then pick another
   always @(negedge clock) begin
      if (stall_hold == 0) begin
         case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 20;
            2: stall_pct = 50;
            default: stall_pct = 85;
         endcase
         stall_hold = $urandom_range(16, 96);
      end
      stall_hold--;
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   always @(posedge clock) begin
      keeper_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (drain_results_due.size() == 0) begin
            $error("result with none expected: len %0h rows %0h %0h", rsp_out_len,
                   rsp_out_first_row, rsp_out_second_row);
            fail_count++;
         end else begin
            want = drain_results_due.pop_front();
            check_field("out_len", want.len, rsp_out_len);
            check_field("out_first_row", want.first_row, rsp_out_first_row);
            check_field("out_second_row", want.second_row, rsp_out_second_row);
            check_field("entry_valid", 16'(want.entry_valid), 16'(rsp_entry_valid));
            check_field("last", 16'(want.last), 16'(rsp_last));
         end
      end
   end

   initial begin
      #10_000_000;
      $display("tb_top_k_seed_keeper_top: errors");
      $finish;
   end

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_type       = REQ_OFFER;
      req_score_len  = '0;
      req_first_row  = '0;
      req_second_row = '0;
      csr_wr_en      = 1'b0;
      csr_index      = CSR_MIN_LENGTH;
      csr_wdata      = '0;
      min_len_reg    = '0;
      keep_limit_reg = LIMIT_W'(KEEP_CAPACITY);
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < PLAN_ROWS; i++) begin
         case (directed_plan[i].kind)
            STEP_SET_MIN: write_register(CSR_MIN_LENGTH, directed_plan[i].len);
            STEP_SET_LIMIT: write_register(CSR_KEEP_LIMIT, directed_plan[i].len);
            default: send_request(directed_plan[i].rtype, directed_plan[i].len,
                                  directed_plan[i].first_row,
                                  directed_plan[i].second_row,
                                  directed_plan[i].typed, directed_plan[i].want);
         endcase
      end

      foreach (random_phases[p]) begin
         write_register(CSR_MIN_LENGTH, random_phases[p].min_random ?
                        FIELD_W'($urandom_range(1000, 40000)) : random_phases[p].min_len);
         write_register(CSR_KEEP_LIMIT, random_phases[p].limit_wdata);
         for (int n = 0; n < random_phases[p].items; n++) begin
            if ($urandom_range(0, 99) < random_phases[p].drain_pct) begin
               send_request(REQ_DRAIN, FIELD_W'($urandom()), FIELD_W'($urandom()),
                            FIELD_W'($urandom()), 1'b0, '0);
            end else begin
               send_random_offer();
            end
         end
         if (random_phases[p].end_drain) begin
            send_request(REQ_DRAIN, FIELD_W'($urandom()), FIELD_W'($urandom()),
                         FIELD_W'($urandom()), 1'b0, '0);
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (drain_results_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_top_k_seed_keeper_top: clean");
      end else begin
         $display("tb_top_k_seed_keeper_top: errors");
      end
      $finish;
   end

endmodule
